[rtl/gis_pkg.sv]
// Shared types and constants for the greedy independent set core.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package gis_pkg;

	// Default store size and fixed field widths.
	localparam int GIS_MAX_VERTICES = 64;
	localparam int VTX_W = 7;
	localparam int CMD_W = 2;

	// Command codes carried on the command port.
	localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture_edge; // add edge accepted: latch the edge, read its row
		logic start_walk; // compute accepted: reset walk state, read row one
		logic clear_all; // clear accepted: drop every row valid bit
		logic write_row; // write the updated row back
		logic walk; // evaluate one vertex
		logic flush; // emit the held vertex as the final result
	} gis_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_done; // the vertex under evaluation is the last one
	} gis_stat_t;

endpackage

[rtl/greedy_independent_set_core.sv]
// Top level of the greedy independent set core: controller plus datapath.
// Depends on gis_pkg, gis_ctrl and gis_datapath.
//
//  channel   signals                                      direction  handshake
//  command   start, command, edge_from, edge_to, busy     in         start && !busy
//  config    cfg_valid, cfg_wdata, cfg_ready              in         cfg_valid && cfg_ready
//  result    result_strobe, picked_vertex, last_of_set    out        strobe, one cycle
//
// Add edge: busy after the beat while the row read at acceptance is written back.
// Clear: done at the accepting edge; busy stays low. Unused code 3 is ignored.
// Compute: busy through the walk over the live vertices, which reads the adjacency memory
// one row per cycle, and the flush step; results appear as strobes during and just after.
// Reset empties the graph at once through per-row valid bits; no clearing pass.
// The result side cannot stall; cfg_ready is always high.
module greedy_independent_set_core #(
	parameter int MAX_VERTICES = gis_pkg::GIS_MAX_VERTICES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [gis_pkg::CMD_W-1:0] command,
	input  logic [gis_pkg::VTX_W-1:0] edge_from,
	input  logic [gis_pkg::VTX_W-1:0] edge_to,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [gis_pkg::VTX_W-1:0] cfg_wdata,
	output logic                      result_strobe,
	output logic [gis_pkg::VTX_W-1:0] picked_vertex,
	output logic                      last_of_set
);

	gis_pkg::gis_cmd_t  cmd;
	gis_pkg::gis_stat_t status;

	gis_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy)
	);

	gis_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_wdata     (cfg_wdata),
		.edge_from     (edge_from),
		.edge_to       (edge_to),
		.cmd           (cmd),
		.status        (status),
		.result_strobe (result_strobe),
		.picked_vertex (picked_vertex),
		.last_of_set   (last_of_set)
	);

endmodule

[rtl/gis_ctrl.sv]
// Controller state machine for the greedy independent set core.
// Depends on gis_pkg for command codes and the command and status structs.
module gis_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gis_pkg::CMD_W-1:0] command,
	input  gis_pkg::gis_stat_t        status,
	output gis_pkg::gis_cmd_t         cmd,
	output logic                      busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD_WR,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;
	assign busy = busy_q;

	// Decode the accepted command and the current state into datapath commands.
	always_comb begin
		cmd = '0;
		cmd.capture_edge = accept && (command == gis_pkg::CMD_ADD_EDGE);
		cmd.start_walk = accept && (command == gis_pkg::CMD_COMPUTE);
		cmd.clear_all = accept && (command == gis_pkg::CMD_CLEAR);
		cmd.write_row = (state_q == ST_ADD_WR);
		cmd.walk = (state_q == ST_WALK);
		cmd.flush = (state_q == ST_FLUSH);
	end

	// State register and registered busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && command == gis_pkg::CMD_ADD_EDGE) begin
						state_q <= ST_ADD_WR;
						busy_q <= 1'b1;
					end else if (accept && command == gis_pkg::CMD_COMPUTE) begin
						state_q <= ST_WALK;
						busy_q <= 1'b1;
					end
				end
				ST_ADD_WR: begin
					state_q <= ST_IDLE;
					busy_q <= 1'b0;
				end
				ST_WALK: begin
					if (status.walk_done) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
					busy_q <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	// The walk always ends in the flush step.
	a_walk_to_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && status.walk_done) |=> (state_q == ST_FLUSH))
		else $error("walk did not end in flush");

	// Busy is high exactly when the machine is away from idle.
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != ST_IDLE))
		else $error("busy flag out of step with state");

endmodule

[rtl/gis_datapath.sv]
// Datapath of the greedy independent set core: vertex count register, adjacency
// memory with row valid bits, walk registers and result registers. Depends on gis_pkg.
module gis_datapath #(
	parameter int MAX_VERTICES = gis_pkg::GIS_MAX_VERTICES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [gis_pkg::VTX_W-1:0] cfg_wdata,
	input  logic [gis_pkg::VTX_W-1:0] edge_from,
	input  logic [gis_pkg::VTX_W-1:0] edge_to,
	input  gis_pkg::gis_cmd_t         cmd,
	output gis_pkg::gis_stat_t        status,
	output logic                      result_strobe,
	output logic [gis_pkg::VTX_W-1:0] picked_vertex,
	output logic                      last_of_set
);

	localparam int VW = gis_pkg::VTX_W;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam logic [VW-1:0] MAX_V = VW'(MAX_VERTICES);
	localparam logic [VW-1:0] ONE_V = VW'(1);
	localparam logic [MAX_VERTICES-1:0] ONE_ROW = MAX_VERTICES'(1);

	// Adjacency memory: an edge is kept once, in the row of its higher vertex.
	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] rd_data_q;
	logic                    rd_valid_q;
	logic [MAX_VERTICES-1:0] row_valid_q;

	logic [VW-1:0]           vertex_count_q;
	logic [VW-1:0]           live_count;
	logic [VW-1:0]           cnt_q;
	logic [VW-1:0]           cur_q;
	logic [VW-1:0]           pend_q;
	logic                    pend_valid_q;
	logic [MAX_VERTICES-1:0] picked_q;

	logic [IDX_W-1:0]        wr_idx_q;
	logic [IDX_W-1:0]        bit_idx_q;
	logic                    edge_ok_q;

	logic                    strobe_q;
	logic [VW-1:0]           vertex_q;
	logic                    last_q;

	logic                    edge_ok;
	logic [VW-1:0]           hi_v;
	logic [VW-1:0]           lo_v;
	logic [VW-1:0]           hi_m1;
	logic [VW-1:0]           lo_m1;
	logic [VW-1:0]           cur_m1;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_idx;
	logic [MAX_VERTICES-1:0] row_eff;
	logic [MAX_VERTICES-1:0] wr_row;
	logic                    pick;

	assign cfg_ready = 1'b1;

	// Vertex count as used: zero acts as one, anything above the store size as the size.
	always_comb begin
		if (vertex_count_q == '0) begin
			live_count = ONE_V;
		end else if (vertex_count_q > MAX_V) begin
			live_count = MAX_V;
		end else begin
			live_count = vertex_count_q;
		end
	end

	// Edge check and ordering of the two endpoints.
	assign edge_ok = (edge_from != '0) && (edge_from <= live_count)
		&& (edge_to != '0) && (edge_to <= live_count);
	assign hi_v = (edge_from > edge_to) ? edge_from : edge_to;
	assign lo_v = (edge_from > edge_to) ? edge_to : edge_from;
	assign hi_m1 = hi_v - ONE_V;
	assign lo_m1 = lo_v - ONE_V;
	assign cur_m1 = cur_q - ONE_V;

	// Read port: the edge's row on capture, row one on walk start, then the next vertex.
	assign status.walk_done = (cur_q == cnt_q);
	assign rd_en = (cmd.capture_edge && edge_ok) || cmd.start_walk
		|| (cmd.walk && !status.walk_done);
	always_comb begin
		if (cmd.capture_edge) begin
			rd_idx = hi_m1[IDX_W-1:0];
		end else if (cmd.start_walk) begin
			rd_idx = '0;
		end else begin
			rd_idx = cur_q[IDX_W-1:0];
		end
	end

	// A row never written since reset or clear reads as empty.
	assign row_eff = rd_valid_q ? rd_data_q : '0;
	assign wr_row = row_eff | (ONE_ROW << bit_idx_q);

	// Picked mask holds only lower vertices, so a self-loop never blocks.
	assign pick = ~|(row_eff & picked_q);

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.write_row && edge_ok_q) begin
			mem[wr_idx_q] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	// Row valid bits and the valid flag that travels with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_all) begin
				row_valid_q <= '0;
			end else if (cmd.write_row && edge_ok_q) begin
				row_valid_q[wr_idx_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= row_valid_q[rd_idx];
			end
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VW'(64);
		end else if (cfg_valid) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// Edge capture: row and bit position of the edge.
	always_ff @(posedge clk) begin
		if (cmd.capture_edge) begin
			wr_idx_q <= hi_m1[IDX_W-1:0];
			bit_idx_q <= lo_m1[IDX_W-1:0];
			edge_ok_q <= edge_ok;
		end
	end

	// Walk registers: one vertex evaluated per cycle.
	always_ff @(posedge clk) begin
		if (cmd.start_walk) begin
			cnt_q <= live_count;
			cur_q <= ONE_V;
			picked_q <= '0;
		end else if (cmd.walk) begin
			cur_q <= cur_q + ONE_V;
			if (pick) begin
				picked_q[cur_m1[IDX_W-1:0]] <= 1'b1;
				pend_q <= cur_q;
			end
		end
	end

	// Pending flag: a picked vertex waits until the next pick or the end tells its flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.start_walk) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.walk && pick) begin
			pend_valid_q <= 1'b1;
		end
	end

	// Result strobe: one cycle per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.walk && pick && pend_valid_q) || cmd.flush;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if ((cmd.walk && pick && pend_valid_q) || cmd.flush) begin
			vertex_q <= pend_q;
			last_q <= cmd.flush;
		end
	end

	assign result_strobe = strobe_q;
	assign picked_vertex = vertex_q;
	assign last_of_set = last_q;

	// Every result lies within the walked range.
	a_vertex_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> (vertex_q != '0) && (vertex_q <= cnt_q))
		else $error("result vertex outside walked range");

	// The first vertex of a walk is always picked.
	a_first_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_walk |=> (cmd.walk && pick))
		else $error("vertex one not picked");

	// A beat that is not final leaves a newer vertex pending.
	a_pend_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !last_q) |-> pend_valid_q)
		else $error("no pending vertex after a non-final beat");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for greedy_independent_set_core: a directed script, then random
// edge, clear, compute and unused-code beats, checked against a bench model or typed sets.
// Depends on gis_pkg and the RTL under rtl/.
module tb_top;

	localparam int NV = gis_pkg::GIS_MAX_VERTICES;
	localparam logic [gis_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [63:0] EVERY_VERTEX = '1;
	localparam logic [63:0] ENDS_BLOCKED = 64'h7FFF_FFFF_FFFF_FFFD;
	localparam int RANDOM_ITEMS = 140;

	typedef struct packed {
		logic [gis_pkg::VTX_W-1:0] vertex;
		logic last;
	} pick_t;

	// One script row: either a vertex count write (value in a) or a command beat.
	// Rows with known set carry the picked set that can be read off directly.
	typedef struct packed {
		bit cfg;
		logic [gis_pkg::CMD_W-1:0] cmd;
		logic [gis_pkg::VTX_W-1:0] a;
		logic [gis_pkg::VTX_W-1:0] b;
		bit known;
		logic [63:0] picks;
	} script_row_t;

	localparam script_row_t SCRIPT [24] = '{
		'{1'b0, gis_pkg::CMD_COMPUTE, 7'd127, 7'd0, 1'b1, EVERY_VERTEX},
		'{1'b0, gis_pkg::CMD_ADD_EDGE, 7'd1, 7'd2, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_ADD_EDGE, 7'd2, 7'd3, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_ADD_EDGE, 7'd63, 7'd64, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_ADD_EDGE, 7'd64, 7'd64, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_ADD_EDGE, 7'd0, 7'd5, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_ADD_EDGE, 7'd5, 7'd127, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_ADD_EDGE, 7'd65, 7'd3, 1'b0, 64'd0},
		'{1'b0, CMD_UNUSED, 7'd1, 7'd3, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_COMPUTE, 7'd0, 7'd127, 1'b1, ENDS_BLOCKED},
		'{1'b1, gis_pkg::CMD_ADD_EDGE, 7'd1, 7'd0, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_COMPUTE, 7'd0, 7'd0, 1'b1, 64'h1},
		'{1'b1, gis_pkg::CMD_ADD_EDGE, 7'd0, 7'd0, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_COMPUTE, 7'd0, 7'd0, 1'b1, 64'h1},
		'{1'b1, gis_pkg::CMD_ADD_EDGE, 7'd127, 7'd0, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_COMPUTE, 7'd0, 7'd0, 1'b1, ENDS_BLOCKED},
		'{1'b1, gis_pkg::CMD_ADD_EDGE, 7'd3, 7'd0, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_ADD_EDGE, 7'd3, 7'd4, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_COMPUTE, 7'd0, 7'd0, 1'b1, 64'h5},
		'{1'b1, gis_pkg::CMD_ADD_EDGE, 7'd64, 7'd0, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_COMPUTE, 7'd0, 7'd0, 1'b1, ENDS_BLOCKED},
		'{1'b0, gis_pkg::CMD_CLEAR, 7'd0, 7'd0, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_ADD_EDGE, 7'd1, 7'd1, 1'b0, 64'd0},
		'{1'b0, gis_pkg::CMD_COMPUTE, 7'd0, 7'd0, 1'b1, EVERY_VERTEX}
	};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [gis_pkg::CMD_W-1:0] command;
	logic [gis_pkg::VTX_W-1:0] edge_from;
	logic [gis_pkg::VTX_W-1:0] edge_to;
	logic cfg_valid;
	logic cfg_ready;
	logic [gis_pkg::VTX_W-1:0] cfg_wdata;
	logic result_strobe;
	logic [gis_pkg::VTX_W-1:0] picked_vertex;
	logic last_of_set;

	// Picked set typed into the script for the beat now on the command port.
	logic known_now;
	logic [63:0] picks_now;

	// Model state: adjacency rows, last picked set and the vertex count register.
	logic [63:0] adj_rows [NV];
	logic [63:0] set_mask;
	logic [gis_pkg::VTX_W-1:0] count_reg;
	pick_t picks_due [$];
	int mismatches = 0;
	bit steady;

	greedy_independent_set_core #(
		.MAX_VERTICES(NV)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.edge_from(edge_from),
		.edge_to(edge_to),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_wdata(cfg_wdata),
		.result_strobe(result_strobe),
		.picked_vertex(picked_vertex),
		.last_of_set(last_of_set)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[greedy_independent_set_core] ERROR");
		$finish;
	end

	// A count of zero behaves as one, anything above the store size as the store size.
	function automatic int live_vertices(logic [gis_pkg::VTX_W-1:0] c);
		if (c == 0) return 1;
		if (c > NV) return NV;
		return int'(c);
	endfunction

	// Applies one accepted command to the model; returns the picked set for a compute.
	function automatic logic [63:0] step_graph(logic [gis_pkg::CMD_W-1:0] cmd,
			logic [gis_pkg::VTX_W-1:0] a, logic [gis_pkg::VTX_W-1:0] b);
		int n;
		logic [63:0] others;
		n = live_vertices(count_reg);
		case (cmd)
			gis_pkg::CMD_ADD_EDGE: begin
				// Edges with an endpoint outside the live range are dropped.
				if (a >= 1 && a <= n && b >= 1 && b <= n) begin
					adj_rows[a - 1][b - 1] = 1'b1;
					adj_rows[b - 1][a - 1] = 1'b1;
				end
			end
			gis_pkg::CMD_CLEAR: begin
				foreach (adj_rows[i]) adj_rows[i] = '0;
				set_mask = '0;
			end
			gis_pkg::CMD_COMPUTE: begin
				set_mask = '0;
				for (int v = 1; v <= n; v++) begin
					// A self-loop never blocks its own vertex.
					others = set_mask & ~(64'd1 << (v - 1));
					if ((adj_rows[v - 1] & others) == '0) set_mask[v - 1] = 1'b1;
				end
			end
			default: ;
		endcase
		return (cmd == gis_pkg::CMD_COMPUTE) ? set_mask : '0;
	endfunction

	// Tracks accepted beats and checks every result strobe against the oldest expectation.
	always @(posedge clk) begin
		logic [63:0] picks;
		int top;
		pick_t due;
		if (!arst_n) begin
			foreach (adj_rows[i]) adj_rows[i] = '0;
			set_mask = '0;
			count_reg = 7'd64;
			picks_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_reg = cfg_wdata;
			end
			if (start && !busy) begin
				picks = step_graph(command, edge_from, edge_to);
				if (command == gis_pkg::CMD_COMPUTE) begin
					if (known_now) picks = picks_now;
					top = 0;
					for (int v = 1; v <= NV; v++) if (picks[v - 1]) top = v;
					for (int v = 1; v <= NV; v++) begin
						if (picks[v - 1]) begin
							picks_due.push_back('{vertex: gis_pkg::VTX_W'(v),
								last: (v == top)});
						end
					end
				end
			end
			if (result_strobe) begin
				if (picks_due.size() == 0) begin
					$error("picked_vertex: expected no result, got %0d", picked_vertex);
					mismatches++;
				end else begin
					due = picks_due.pop_front();
					if (picked_vertex !== due.vertex) begin
						$error("picked_vertex: expected %0d, got %0d", due.vertex, picked_vertex);
						mismatches++;
					end
					if (last_of_set !== due.last) begin
						$error("last_of_set: expected %0d, got %0d", due.last, last_of_set);
						mismatches++;
					end
				end
			end
		end
	end

	// Presents one command beat, after a random gap unless steady, and holds it until accepted.
	task automatic send_item(input logic [gis_pkg::CMD_W-1:0] cmd,
			input logic [gis_pkg::VTX_W-1:0] a, input logic [gis_pkg::VTX_W-1:0] b,
			input bit known, input logic [63:0] picks);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		edge_from <= a;
		edge_to <= b;
		known_now <= known;
		picks_now <= picks;
		do @(posedge clk); while (busy);
	endtask

	// Lets the core drain: no beat pending, not busy, every expected result seen.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (picks_due.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// Writes the vertex count register once the core is idle.
	task automatic write_count(input logic [gis_pkg::VTX_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_wdata <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int n;
		int counted;
		int r;
		logic [gis_pkg::CMD_W-1:0] cmd;
		logic [gis_pkg::VTX_W-1:0] a;
		logic [gis_pkg::VTX_W-1:0] b;
		logic [gis_pkg::VTX_W-1:0] cfg_val;
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= gis_pkg::CMD_ADD_EDGE;
		edge_from <= '0;
		edge_to <= '0;
		cfg_valid <= 1'b0;
		cfg_wdata <= '0;
		known_now <= 1'b0;
		picks_now <= '0;
		steady = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script: reset state, range limits, self-loops, unused code, count extremes.
		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].cfg) begin
				write_count(SCRIPT[i].a);
			end else begin
				send_item(SCRIPT[i].cmd, SCRIPT[i].a, SCRIPT[i].b, SCRIPT[i].known,
					SCRIPT[i].picks);
			end
		end

		// Random phases: a new vertex count, maybe a clear, mostly legal edges, then a compute.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			case (r)
				0: cfg_val = 7'd1;
				1: cfg_val = 7'd64;
				2: cfg_val = $urandom_range(0, 1) ? 7'd127 : 7'd0;
				3: cfg_val = 7'($urandom_range(0, 127));
				default: cfg_val = 7'($urandom_range(2, 12));
			endcase
			write_count(cfg_val);
			n = live_vertices(cfg_val);
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) begin
				send_item(gis_pkg::CMD_CLEAR, 7'($urandom_range(0, 127)),
					7'($urandom_range(0, 127)), 1'b0, '0);
				counted++;
			end
			repeat ($urandom_range(4, 24)) begin
				r = $urandom_range(0, 99);
				a = 7'($urandom_range(0, 127));
				b = 7'($urandom_range(0, 127));
				if (r < 6) begin
					cmd = gis_pkg::CMD_CLEAR;
				end else if (r < 18) begin
					cmd = gis_pkg::CMD_COMPUTE;
				end else if (r < 26) begin
					// Noise: the unused code or an edge with arbitrary endpoints.
					cmd = $urandom_range(0, 1) ? CMD_UNUSED : gis_pkg::CMD_ADD_EDGE;
				end else begin
					cmd = gis_pkg::CMD_ADD_EDGE;
					a = 7'($urandom_range(1, n));
					b = 7'($urandom_range(1, n));
				end
				send_item(cmd, a, b, 1'b0, '0);
				counted++;
			end
			send_item(gis_pkg::CMD_COMPUTE, 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)), 1'b0, '0);
			counted++;
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("[greedy_independent_set_core] OK");
		end else begin
			$display("[greedy_independent_set_core] ERROR");
		end
		$finish;
	end

endmodule
